/* sv/assert_macros.svh */
// Assertion macros used by the top RTL file of the grid index block.
// Defining ASSERT_OFF turns every assertion into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/c2g_pkg.sv */
// Package of the grid index block: widths, register indexes, shared types
// and the saturation helpers used by the axis lanes. No dependencies.
package c2g_pkg;

    localparam int INDEX_WIDTH = 16;
    localparam int FRAC_BITS   = 16;

    localparam int WORD_W  = 32;
    localparam int MIN_W   = 16;
    localparam int GRID_W  = 3 * MIN_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = GRID_W;

    // Q8.24 coefficient times Q16.16 position gives 40 fraction bits.
    localparam int PROD_W = 2 * WORD_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SHIFT  = 40 - FRAC_BITS;
    localparam int F_W    = SUM_W - SHIFT;
    localparam int QW     = F_W + 3;

    localparam logic [CFG_IDX_W-1:0] REG_C00  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_C01  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_C02  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_C11  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_C12  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_C22  = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_GMIN = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_GMAX = CFG_IDX_W'(7);

    localparam logic signed [QW-1:0] ONE_Q  = QW'(longint'(1) <<< FRAC_BITS);
    localparam logic signed [QW-1:0] HALF_Q = QW'(longint'(1) <<< (FRAC_BITS - 1));
    localparam logic signed [QW-1:0] NEG_ONE_Q = '1;
    localparam logic signed [QW-1:0] IDX_HI =
        QW'((longint'(1) <<< (INDEX_WIDTH - 1)) - 1);
    localparam logic signed [QW-1:0] IDX_LO = -IDX_HI - QW'(1);
    localparam logic signed [QW-1:0] OFF_HI =
        QW'((longint'(1) <<< (WORD_W - 1)) - 1);
    localparam logic signed [QW-1:0] OFF_LO = -OFF_HI - QW'(1);

    typedef logic signed [WORD_W-1:0]      word_t;
    typedef logic signed [MIN_W-1:0]       grid_t;
    typedef logic signed [INDEX_WIDTH-1:0] index_t;

    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } lane_ctl_t;

    typedef struct packed {
        index_t lower;
        index_t nearest;
        word_t  offs;
        logic   in_box;
        logic   err;
    } quant_t;

    function automatic index_t sat_index(input logic signed [QW-1:0] v);
        logic signed [QW-1:0] c;
        c = (v > IDX_HI) ? IDX_HI : ((v < IDX_LO) ? IDX_LO : v);
        return c[INDEX_WIDTH-1:0];
    endfunction

    function automatic word_t sat_word(input logic signed [QW-1:0] v);
        logic signed [QW-1:0] c;
        c = (v > OFF_HI) ? OFF_HI : ((v < OFF_LO) ? OFF_LO : v);
        return c[WORD_W-1:0];
    endfunction

endpackage

/* sv/c2g_ifs.sv */
// Channel interfaces of the grid index block: input point, result and
// configuration write. Depends on c2g_pkg.
interface c2g_point_if import c2g_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface c2g_result_if import c2g_pkg::*; ();
    logic   valid;
    logic   ready;
    index_t lower_a;
    index_t lower_b;
    index_t lower_c;
    index_t nearest_a;
    index_t nearest_b;
    index_t nearest_c;
    word_t  offset_a;
    word_t  offset_b;
    word_t  offset_c;
    logic   inside_box;
    logic   offset_error;

    modport source (output valid, lower_a, lower_b, lower_c, nearest_a, nearest_b,
                    nearest_c, offset_a, offset_b, offset_c, inside_box,
                    offset_error, input ready);
    modport sink   (input valid, lower_a, lower_b, lower_c, nearest_a, nearest_b,
                    nearest_c, offset_a, offset_b, offset_c, inside_box,
                    offset_error, output ready);
endinterface

interface c2g_cfg_if import c2g_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/cartesian_to_grid_index.sv */
// Converts a Cartesian point (Q16.16 per axis) into fractional cell coordinates
// through an upper-triangular Q8.24 matrix and reports, per axis, the nearest
// and lower grid index and the offset from the lower grid point, plus inside-box
// and offset-error flags. One point is taken every cycle while the pipeline is
// not stalled; each point passes the multiply, sum and merge registers, and a
// stalled result holds the pipeline only once every stage is full. Matrix and
// grid bounds are written through the cfg channel, which is always ready.
// Depends on c2g_pkg, c2g_ifs, c2g_lane, c2g_merge and assert_macros.svh.
`include "assert_macros.svh"

module cartesian_to_grid_index
    import c2g_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    c2g_point_if.sink    point,
    c2g_result_if.source result,
    c2g_cfg_if.sink      cfg
);

    word_t c00_reg, c01_reg, c02_reg, c11_reg, c12_reg, c22_reg;
    logic [GRID_W-1:0] gmin_reg, gmax_reg;

    logic      mul_valid_reg, sum_valid_reg;
    logic      sum_ready, mul_ready, merge_ready;
    lane_ctl_t ctl;
    quant_t    lane_q [3];
    word_t     pos [3];
    word_t     coef_a [3], coef_b [3], coef_c [3];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c00_reg  <= '0;
            c01_reg  <= '0;
            c02_reg  <= '0;
            c11_reg  <= '0;
            c12_reg  <= '0;
            c22_reg  <= '0;
            gmin_reg <= '0;
            gmax_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_C00:  c00_reg  <= cfg.data[WORD_W-1:0];
                REG_C01:  c01_reg  <= cfg.data[WORD_W-1:0];
                REG_C02:  c02_reg  <= cfg.data[WORD_W-1:0];
                REG_C11:  c11_reg  <= cfg.data[WORD_W-1:0];
                REG_C12:  c12_reg  <= cfg.data[WORD_W-1:0];
                REG_C22:  c22_reg  <= cfg.data[WORD_W-1:0];
                REG_GMIN: gmin_reg <= cfg.data[GRID_W-1:0];
                REG_GMAX: gmax_reg <= cfg.data[GRID_W-1:0];
                default:  ;
            endcase
        end
    end

    // Each stage moves on when the stage after it is empty or emptying.
    assign sum_ready   = !sum_valid_reg || merge_ready;
    assign mul_ready   = !mul_valid_reg || sum_ready;
    assign point.ready = mul_ready;

    assign ctl.en_mul = point.valid && mul_ready;
    assign ctl.en_sum = mul_valid_reg && sum_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_ready)
            begin
                mul_valid_reg <= point.valid;
            end
            if (sum_ready)
            begin
                sum_valid_reg <= mul_valid_reg;
            end
        end
    end

    assign pos[0] = point.pos_x;
    assign pos[1] = point.pos_y;
    assign pos[2] = point.pos_z;

    assign coef_a[0] = c00_reg;
    assign coef_a[1] = c01_reg;
    assign coef_a[2] = c02_reg;
    assign coef_b[0] = '0;
    assign coef_b[1] = c11_reg;
    assign coef_b[2] = c12_reg;
    assign coef_c[0] = '0;
    assign coef_c[1] = '0;
    assign coef_c[2] = c22_reg;

    c2g_lane u_lane_a (
        .clk      (clk),
        .ctl      (ctl),
        .coef     (coef_a),
        .pos      (pos),
        .grid_min (gmin_reg[MIN_W-1:0]),
        .grid_max (gmax_reg[MIN_W-1:0]),
        .quant    (lane_q[0])
    );

    c2g_lane u_lane_b (
        .clk      (clk),
        .ctl      (ctl),
        .coef     (coef_b),
        .pos      (pos),
        .grid_min (gmin_reg[2*MIN_W-1:MIN_W]),
        .grid_max (gmax_reg[2*MIN_W-1:MIN_W]),
        .quant    (lane_q[1])
    );

    c2g_lane u_lane_c (
        .clk      (clk),
        .ctl      (ctl),
        .coef     (coef_c),
        .pos      (pos),
        .grid_min (gmin_reg[3*MIN_W-1:2*MIN_W]),
        .grid_max (gmax_reg[3*MIN_W-1:2*MIN_W]),
        .quant    (lane_q[2])
    );

    c2g_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sum_valid_reg),
        .lane_q   (lane_q),
        .can_load (merge_ready),
        .result   (result)
    );

    `ASSERT_NEXT(a_accept_fills_mul, clk, rst_n, point.valid && point.ready, mul_valid_reg)
    `ASSERT_IMPL(a_empty_is_ready, clk, rst_n, !mul_valid_reg && !sum_valid_reg, point.ready)
    `ASSERT_IMPL(a_full_stall, clk, rst_n,
                 mul_valid_reg && sum_valid_reg && result.valid && !result.ready,
                 !point.ready)
    `ASSERT_NEXT(a_sum_to_out, clk, rst_n, sum_valid_reg && merge_ready, result.valid)

endmodule

/* sv/c2g_lane.sv */
// One axis lane: three-term dot product over two register stages, then the
// quantizer that yields lower index, nearest index, offset and flags.
// Depends on c2g_pkg.
module c2g_lane
    import c2g_pkg::*;
(
    input  logic      clk,
    input  lane_ctl_t ctl,
    input  word_t     coef [3],
    input  word_t     pos  [3],
    input  grid_t     grid_min,
    input  grid_t     grid_max,
    output quant_t    quant
);

    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [SUM_W-1:0]  sum;
    logic signed [F_W-1:0]    f_reg;

    logic signed [QW-1:0] fq, mnq, mxq, intg, rnd, lower_w, base, offs_w;
    logic                 neg_frac;

    always_ff @(posedge clk)
    begin
        if (ctl.en_mul)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= PROD_W'(coef[k]) * PROD_W'(pos[k]);
            end
        end
    end

    assign sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2]);

    // Dropping the low bits rounds the exact sum toward minus infinity.
    always_ff @(posedge clk)
    begin
        if (ctl.en_sum)
        begin
            f_reg <= sum[SUM_W-1:SHIFT];
        end
    end

    always_comb
    begin
        fq   = QW'(f_reg);
        mnq  = QW'(grid_min);
        mxq  = QW'(grid_max);
        intg = fq >>> FRAC_BITS;
        neg_frac = f_reg[F_W-1] && (|f_reg[FRAC_BITS-1:0]);

        // Round half away from zero.
        if (f_reg[F_W-1])
        begin
            rnd = -((-fq + HALF_Q) >>> FRAC_BITS);
        end
        else
        begin
            rnd = (fq + HALF_Q) >>> FRAC_BITS;
        end

        // A negative coordinate with a fraction lands in the cell before the grid.
        lower_w = neg_frac ? NEG_ONE_Q : (intg - mnq);
        base    = neg_frac ? (mnq - QW'(1)) : intg;
        offs_w  = fq - (base <<< FRAC_BITS);

        quant.lower   = sat_index(lower_w);
        quant.nearest = sat_index(rnd - mnq);
        quant.offs    = sat_word(offs_w);
        quant.err     = (offs_w < QW'(0)) || (offs_w >= ONE_Q);
        quant.in_box  = (fq >= (mnq <<< FRAC_BITS)) && (fq <= (mxq <<< FRAC_BITS));
    end

endmodule

/* sv/c2g_merge.sv */
// Merge stage: registers the three lane results into the output beat and
// combines the per-axis inside and error flags. Depends on c2g_pkg and c2g_ifs.
module c2g_merge
    import c2g_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  quant_t  lane_q [3],
    output logic    can_load,
    c2g_result_if.source result
);

    logic   valid_reg;
    quant_t q_reg [3];
    logic   inside_reg;
    logic   err_reg;
    logic   load;

    assign can_load = !valid_reg || result.ready;
    assign load     = in_valid && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg      <= lane_q;
            inside_reg <= lane_q[0].in_box && lane_q[1].in_box && lane_q[2].in_box;
            err_reg    <= lane_q[0].err || lane_q[1].err || lane_q[2].err;
        end
    end

    assign result.valid        = valid_reg;
    assign result.lower_a      = q_reg[0].lower;
    assign result.lower_b      = q_reg[1].lower;
    assign result.lower_c      = q_reg[2].lower;
    assign result.nearest_a    = q_reg[0].nearest;
    assign result.nearest_b    = q_reg[1].nearest;
    assign result.nearest_c    = q_reg[2].nearest;
    assign result.offset_a     = q_reg[0].offs;
    assign result.offset_b     = q_reg[1].offs;
    assign result.offset_c     = q_reg[2].offs;
    assign result.inside_box   = inside_reg;
    assign result.offset_error = err_reg;

endmodule
